FILE: src/particle_euler_integrator_unit_assert.svh
// Assertion macros shared by the particle integrator modules.
`ifndef PARTICLE_EULER_INTEGRATOR_UNIT_ASSERT_SVH
`define PARTICLE_EULER_INTEGRATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define PEI_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pei assertion failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define PEI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pei assertion failed");
`else
`define PEI_ASSERT_IMPL(lbl, ante, cons)
`define PEI_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: src/pei_pkg.sv
// Package with control word types, codes and the microprogram of the integrator.
package pei_pkg;

	// Fixed formats.
	localparam int FRAC_BITS = 16;
	localparam int DAMP_BITS = 17;
	localparam logic [DAMP_BITS-1:0] ONE_Q16 = 17'h10000;

	// Configuration register indexes.
	localparam int CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] REG_INV_MASS = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DAMPING  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_ACCEL_X  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_ACCEL_Y  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_ACCEL_Z  = 3'd4;

	// Program addresses.
	localparam int PC_BITS = 4;
	localparam logic [PC_BITS-1:0] PC_WAIT    = 4'd0;
	localparam logic [PC_BITS-1:0] PC_SQR     = 4'd1;
	localparam logic [PC_BITS-1:0] PC_DMUL    = 4'd2;
	localparam logic [PC_BITS-1:0] PC_POS_MUL = 4'd3;
	localparam logic [PC_BITS-1:0] PC_POS_ADD = 4'd4;
	localparam logic [PC_BITS-1:0] PC_ACC_MUL = 4'd5;
	localparam logic [PC_BITS-1:0] PC_ACC_ADD = 4'd6;
	localparam logic [PC_BITS-1:0] PC_VEL_MUL = 4'd7;
	localparam logic [PC_BITS-1:0] PC_VEL_ADD = 4'd8;
	localparam logic [PC_BITS-1:0] PC_DAMP    = 4'd9;
	localparam logic [PC_BITS-1:0] PC_OUT     = 4'd10;

	// Operation codes.
	localparam logic [1:0] OP_WAIT = 2'd0;
	localparam logic [1:0] OP_MUL  = 2'd1;
	localparam logic [1:0] OP_ALU  = 2'd2;
	localparam logic [1:0] OP_OUT  = 2'd3;

	// Multiplier operand selects.
	localparam logic [1:0] A_VEL   = 2'd0;
	localparam logic [1:0] A_FORCE = 2'd1;
	localparam logic [1:0] A_ACC   = 2'd2;
	localparam logic [1:0] A_P     = 2'd3;
	localparam logic [1:0] B_T     = 2'd0;
	localparam logic [1:0] B_IM    = 2'd1;
	localparam logic [1:0] B_P     = 2'd2;
	localparam logic [1:0] B_D     = 2'd3;

	// Destinations.
	localparam logic [2:0] DST_NONE = 3'd0;
	localparam logic [2:0] DST_MR   = 3'd1;
	localparam logic [2:0] DST_P    = 3'd2;
	localparam logic [2:0] DST_VEL  = 3'd3;
	localparam logic [2:0] DST_POS  = 3'd4;
	localparam logic [2:0] DST_ACC  = 3'd5;

	// Step conditions.
	localparam logic COND_ALWAYS = 1'b0;
	localparam logic COND_TBIT   = 1'b1;

	// Branch kinds.
	localparam logic [2:0] BR_NONE      = 3'd0;
	localparam logic [2:0] BR_SKIP      = 3'd1;
	localparam logic [2:0] BR_LOOP_BIT  = 3'd2;
	localparam logic [2:0] BR_LOOP_COMP = 3'd3;
	localparam logic [2:0] BR_GOTO      = 3'd4;

	typedef struct packed {
		logic [1:0]         op;
		logic [1:0]         asel;
		logic [1:0]         bsel;
		logic               sh16;
		logic [2:0]         dst;
		logic               cond;
		logic [2:0]         br;
		logic [PC_BITS-1:0] target;
	} ctrl_t;

	// Conditions reported by the datapath to the sequencer.
	typedef struct packed {
		logic in_valid;
		logic skip;
		logic tbit;
		logic bit_last;
		logic comp_last;
		logic mul_done;
		logic out_free;
	} seq_stat_t;

	// Strobes from the sequencer to the datapath.
	typedef struct packed {
		ctrl_t cw;
		logic  in_ready;
		logic  mul_start;
		logic  wr;
		logic  bit_dec;
		logic  comp_inc;
	} seq_ctl_t;

	// Microprogram ROM: one control word per step.
	function automatic ctrl_t ucode(input logic [PC_BITS-1:0] pc);
		ctrl_t w;
		w = '{op: OP_ALU, asel: A_VEL, bsel: B_T, sh16: 1'b0, dst: DST_NONE,
			cond: COND_ALWAYS, br: BR_NONE, target: PC_WAIT};
		case (pc)
			PC_WAIT: begin
				w.op = OP_WAIT;
				w.br = BR_SKIP;
				w.target = PC_OUT;
			end
			PC_SQR: begin
				w.op = OP_MUL;
				w.asel = A_P;
				w.bsel = B_P;
				w.sh16 = 1'b1;
				w.dst = DST_P;
			end
			PC_DMUL: begin
				w.op = OP_MUL;
				w.asel = A_P;
				w.bsel = B_D;
				w.sh16 = 1'b1;
				w.dst = DST_P;
				w.cond = COND_TBIT;
				w.br = BR_LOOP_BIT;
				w.target = PC_SQR;
			end
			PC_POS_MUL: begin
				w.op = OP_MUL;
				w.asel = A_VEL;
				w.bsel = B_T;
				w.dst = DST_MR;
			end
			PC_POS_ADD: begin
				w.dst = DST_POS;
			end
			PC_ACC_MUL: begin
				w.op = OP_MUL;
				w.asel = A_FORCE;
				w.bsel = B_IM;
				w.sh16 = 1'b1;
				w.dst = DST_MR;
			end
			PC_ACC_ADD: begin
				w.dst = DST_ACC;
			end
			PC_VEL_MUL: begin
				w.op = OP_MUL;
				w.asel = A_ACC;
				w.bsel = B_T;
				w.dst = DST_MR;
			end
			PC_VEL_ADD: begin
				w.dst = DST_VEL;
			end
			PC_DAMP: begin
				w.op = OP_MUL;
				w.asel = A_VEL;
				w.bsel = B_P;
				w.sh16 = 1'b1;
				w.dst = DST_VEL;
				w.br = BR_LOOP_COMP;
				w.target = PC_POS_MUL;
			end
			PC_OUT: begin
				w.op = OP_OUT;
				w.br = BR_GOTO;
				w.target = PC_WAIT;
			end
			default: begin
				w.br = BR_GOTO;
			end
		endcase
		return w;
	endfunction

endpackage

FILE: src/pei_mul.sv
// Shared unsigned multiplier that builds the product from limb products over cycles.
`include "particle_euler_integrator_unit_assert.svh"

module pei_mul import pei_pkg::*; #(
	parameter int A_BITS = 32,
	parameter int B_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [A_BITS-1:0]        a,
	input  logic [B_BITS-1:0]        b,
	output logic                     done,
	output logic [A_BITS+B_BITS-1:0] prod
);

	localparam int LA  = (A_BITS + 31) / 32;
	localparam int LB  = (B_BITS + 31) / 32;
	localparam int LWA = (A_BITS + LA - 1) / LA;
	localparam int LWB = (B_BITS + LB - 1) / LB;
	localparam int PWM = LA * LWA + LB * LWB;
	localparam int IAW = (LA > 1) ? $clog2(LA) : 1;
	localparam int IBW = (LB > 1) ? $clog2(LB) : 1;

	logic [LA*LWA-1:0]    a_pad;
	logic [LB*LWB-1:0]    b_pad;
	logic [LWA-1:0]       a_limb;
	logic [LWB-1:0]       b_limb;
	logic [LWA+LWB-1:0]   pp;
	logic [PWM-1:0]       term;
	logic                 last;
	logic                 busy_q;
	logic                 done_q;
	logic [IAW-1:0]       ia_q;
	logic [IBW-1:0]       ib_q;
	logic [PWM-1:0]       acc_q;

	// One limb product per cycle, placed at its weight.
	assign a_pad  = (LA * LWA)'(a);
	assign b_pad  = (LB * LWB)'(b);
	assign a_limb = a_pad[ia_q * LWA +: LWA];
	assign b_limb = b_pad[ib_q * LWB +: LWB];
	assign pp     = a_limb * b_limb;
	assign term   = PWM'(pp) << (LWA * int'(ia_q) + LWB * int'(ib_q));
	assign last   = (ia_q == IAW'(LA - 1)) && (ib_q == IBW'(LB - 1));

	// Limb counters and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ia_q   <= '0;
			ib_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start || busy_q) begin
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					ia_q   <= '0;
					ib_q   <= '0;
				end else begin
					busy_q <= 1'b1;
					if (ib_q == IBW'(LB - 1)) begin
						ib_q <= '0;
						ia_q <= ia_q + 1'b1;
					end else begin
						ib_q <= ib_q + 1'b1;
					end
				end
			end
		end
	end

	// Product accumulator.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= term;
		end else if (busy_q) begin
			acc_q <= acc_q + term;
		end
	end

	assign done = done_q;
	assign prod = acc_q[A_BITS+B_BITS-1:0];

	`PEI_ASSERT_IMPL(a_mul_no_overlap, start, !busy_q)
	`PEI_ASSERT_IMPL(a_mul_done_src, done_q, $past(start || busy_q))

endmodule

FILE: src/pei_seq.sv
// Microprogram sequencer: step counter, control word fetch and conditional jumps.
`include "particle_euler_integrator_unit_assert.svh"

module pei_seq import pei_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  seq_stat_t stat,
	output seq_ctl_t  ctl
);

	logic [PC_BITS-1:0] pc_q;
	logic [PC_BITS-1:0] pc_next;
	logic               mwait_q;
	logic               run;
	logic               fin;
	ctrl_t              cw;

	// Decode the current step and decide whether it completes.
	always_comb begin
		cw            = ucode(pc_q);
		run           = !((cw.cond == COND_TBIT) && !stat.tbit);
		fin           = 1'b0;
		ctl.cw        = cw;
		ctl.in_ready  = (cw.op == OP_WAIT);
		ctl.mul_start = 1'b0;
		ctl.wr        = 1'b0;
		ctl.bit_dec   = 1'b0;
		ctl.comp_inc  = 1'b0;
		case (cw.op)
			OP_WAIT: begin
				fin    = stat.in_valid;
				ctl.wr = stat.in_valid;
			end
			OP_MUL: begin
				if (!run) begin
					fin = 1'b1;
				end else if (!mwait_q) begin
					ctl.mul_start = 1'b1;
				end else if (stat.mul_done) begin
					fin    = 1'b1;
					ctl.wr = 1'b1;
				end
			end
			OP_ALU: begin
				fin    = 1'b1;
				ctl.wr = 1'b1;
			end
			OP_OUT: begin
				fin    = stat.out_free;
				ctl.wr = stat.out_free;
			end
			default: begin
				fin = 1'b1;
			end
		endcase

		// Next step address.
		pc_next = pc_q + 1'b1;
		case (cw.br)
			BR_NONE: begin
				pc_next = pc_q + 1'b1;
			end
			BR_SKIP: begin
				if (stat.skip) begin
					pc_next = cw.target;
				end
			end
			BR_LOOP_BIT: begin
				if (!stat.bit_last) begin
					pc_next     = cw.target;
					ctl.bit_dec = fin;
				end
			end
			BR_LOOP_COMP: begin
				if (!stat.comp_last) begin
					pc_next      = cw.target;
					ctl.comp_inc = fin;
				end
			end
			BR_GOTO: begin
				pc_next = cw.target;
			end
			default: begin
				pc_next = PC_WAIT;
			end
		endcase
	end

	// Step counter and multiplier wait flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= PC_WAIT;
			mwait_q <= 1'b0;
		end else begin
			if (fin) begin
				pc_q <= pc_next;
			end
			if (ctl.mul_start) begin
				mwait_q <= 1'b1;
			end else if (fin) begin
				mwait_q <= 1'b0;
			end
		end
	end

	`PEI_ASSERT_IMPL(a_pc_range, 1'b1, pc_q <= PC_OUT)
	`PEI_ASSERT_IMPL(a_mul_wr_done, ctl.wr && (cw.op == OP_MUL), stat.mul_done)

endmodule

FILE: src/particle_euler_integrator_unit.sv
// Each multiply runs on the one shared multiplier. A damping step skips its multiply by the
// damping factor when the time bit is clear; an item with zero inverse mass goes straight to
// the output step. One item is processed at a time; the result register lets the next item
// enter while a result waits. Asynchronous reset clears position, velocity and the
// configuration registers to their defaults; no clearing pass is needed.
`include "particle_euler_integrator_unit_assert.svh"

module particle_euler_integrator_unit import pei_pkg::*; #(
	parameter int WORD_BITS = 32,
	parameter int TIME_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input items.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// Fields from bit 0: elapsed_ticks, force_x, force_y, force_z, zero fill.
	input  logic [((TIME_BITS + 3 * WORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// Result items.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// Fields from bit 0: pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, zero fill.
	output logic [((6 * WORD_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	// Fields from bit 0: skipped.
	output logic                  m_tuser,
	// Configuration writes.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [((WORD_BITS > DAMP_BITS) ? WORD_BITS : DAMP_BITS) - 1:0] cfg_data
);

	localparam int W        = WORD_BITS;
	localparam int TB       = TIME_BITS;
	localparam int OUT_BITS = ((6 * W + 7) / 8) * 8;
	localparam int IMW      = (W - 1 > DAMP_BITS) ? W - 1 : DAMP_BITS;
	localparam int AW       = (W > DAMP_BITS) ? W : DAMP_BITS;
	localparam int BW0      = (IMW > TB) ? IMW : TB;
	localparam int BW       = BW0;
	localparam int PWP      = AW + BW;
	localparam int TBW      = (TB > 1) ? $clog2(TB) : 1;
	localparam logic signed [W-1:0] WMAX = {1'b0, {(W - 1){1'b1}}};
	localparam logic signed [W-1:0] WMIN = {1'b1, {(W - 1){1'b0}}};
	localparam logic [PWP:0] RND_BIAS = {{(PWP + 1 - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

	// Configuration registers.
	logic [IMW-1:0]          inv_mass_q;
	logic [DAMP_BITS-1:0]    damp_q;
	logic signed [W-1:0]     accel_q [3];

	// Particle state and working registers.
	logic signed [W-1:0]     pos_q [3];
	logic signed [W-1:0]     vel_q [3];
	logic signed [W-1:0]     force_q [3];
	logic [TB-1:0]           t_q;
	logic [DAMP_BITS-1:0]    p_q;
	logic signed [W-1:0]     acc_q;
	logic signed [W-1:0]     mr_q;
	logic                    skip_q;
	logic [TBW-1:0]          bit_q;
	logic [1:0]              comp_q;

	// Result register.
	logic                    out_valid_q;
	logic [6*W-1:0]          out_data_q;
	logic                    out_skip_q;

	seq_stat_t               stat;
	seq_ctl_t                ctl;
	logic [DAMP_BITS-1:0]    d_clamp;
	logic signed [W-1:0]     a_s;
	logic [W-1:0]            a_mag_w;
	logic                    a_neg;
	logic [AW-1:0]           a_mag;
	logic [BW-1:0]           b_mag;
	logic                    mul_done;
	logic [PWP-1:0]          prod;
	logic [PWP:0]            rnd;
	logic [PWP:0]            q;
	logic                    over;
	logic signed [W-1:0]     mul_res;
	logic [TB-1:0]           t_in;
	logic signed [W-1:0]     force_in [3];

	function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] x,
			input logic signed [W-1:0] y);
		logic signed [W:0] s;
		s = {x[W-1], x} + {y[W-1], y};
		if (s[W] != s[W-1]) begin
			return s[W] ? WMIN : WMAX;
		end
		return s[W-1:0];
	endfunction

	// Input item fields.
	assign t_in = s_tdata[TB-1:0];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			force_in[k] = s_tdata[TB + k * W +: W];
		end
	end

	// Sequencer conditions.
	always_comb begin
		stat.in_valid  = s_tvalid;
		stat.skip      = (inv_mass_q == '0);
		stat.tbit      = t_q[bit_q];
		stat.bit_last  = (bit_q == '0);
		stat.comp_last = (comp_q == 2'd2);
		stat.mul_done  = mul_done;
		stat.out_free  = !out_valid_q || m_tready;
	end

	pei_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	// Multiplier operands as sign and magnitude.
	assign d_clamp = (damp_q > ONE_Q16) ? ONE_Q16 : damp_q;
	always_comb begin
		case (ctl.cw.asel)
			A_VEL:   a_s = vel_q[comp_q];
			A_FORCE: a_s = force_q[comp_q];
			A_ACC:   a_s = acc_q;
			default: a_s = '0;
		endcase
		a_neg   = (ctl.cw.asel != A_P) && a_s[W-1];
		a_mag_w = a_neg ? W'(-a_s) : W'(a_s);
		a_mag   = (ctl.cw.asel == A_P) ? AW'(p_q) : AW'(a_mag_w);
		case (ctl.cw.bsel)
			B_T:     b_mag = BW'(t_q);
			B_IM:    b_mag = BW'(inv_mass_q);
			B_P:     b_mag = BW'(p_q);
			default: b_mag = BW'(d_clamp);
		endcase
	end

	pei_mul #(
		.A_BITS (AW),
		.B_BITS (BW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.mul_start),
		.a      (a_mag),
		.b      (b_mag),
		.done   (mul_done),
		.prod   (prod)
	);

	// Floor toward minus infinity, scale and clamp to the word range.
	always_comb begin
		rnd     = {1'b0, prod} + ((a_neg && ctl.cw.sh16) ? RND_BIAS : '0);
		q       = ctl.cw.sh16 ? (rnd >> FRAC_BITS) : rnd;
		over    = |q[PWP:W-1];
		if (over) begin
			mul_res = a_neg ? WMIN : WMAX;
		end else begin
			mul_res = a_neg ? W'(-q[W-1:0]) : W'(q[W-1:0]);
		end
	end

	// Configuration, particle state and loop counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_mass_q  <= IMW'(ONE_Q16);
			damp_q      <= ONE_Q16;
			out_valid_q <= 1'b0;
			bit_q       <= '0;
			comp_q      <= '0;
			for (int k = 0; k < 3; k++) begin
				accel_q[k] <= '0;
				pos_q[k]   <= '0;
				vel_q[k]   <= '0;
			end
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_INV_MASS: inv_mass_q <= IMW'(cfg_data[W-2:0]);
					REG_DAMPING:  damp_q     <= cfg_data[DAMP_BITS-1:0];
					REG_ACCEL_X:  accel_q[0] <= cfg_data[W-1:0];
					REG_ACCEL_Y:  accel_q[1] <= cfg_data[W-1:0];
					REG_ACCEL_Z:  accel_q[2] <= cfg_data[W-1:0];
					default: begin
					end
				endcase
			end
			if (ctl.wr && (ctl.cw.op == OP_WAIT)) begin
				bit_q  <= TBW'(TB - 1);
				comp_q <= '0;
			end
			if (ctl.bit_dec) begin
				bit_q <= bit_q - 1'b1;
			end
			if (ctl.comp_inc) begin
				comp_q <= comp_q + 1'b1;
			end
			if (ctl.wr && (ctl.cw.op == OP_MUL) && (ctl.cw.dst == DST_VEL)) begin
				vel_q[comp_q] <= mul_res;
			end
			if (ctl.wr && (ctl.cw.op == OP_ALU)) begin
				case (ctl.cw.dst)
					DST_POS: pos_q[comp_q] <= sat_add(pos_q[comp_q], mr_q);
					DST_VEL: vel_q[comp_q] <= sat_add(vel_q[comp_q], mr_q);
					default: begin
					end
				endcase
			end
			if (ctl.wr && (ctl.cw.op == OP_OUT)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working values and the result payload.
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			case (ctl.cw.op)
				OP_WAIT: begin
					t_q    <= t_in;
					skip_q <= stat.skip;
					p_q    <= ONE_Q16;
					for (int k = 0; k < 3; k++) begin
						force_q[k] <= force_in[k];
					end
				end
				OP_MUL: begin
					if (ctl.cw.dst == DST_MR) begin
						mr_q <= mul_res;
					end
					if (ctl.cw.dst == DST_P) begin
						p_q <= prod[FRAC_BITS +: DAMP_BITS];
					end
				end
				OP_ALU: begin
					if (ctl.cw.dst == DST_ACC) begin
						acc_q <= sat_add(accel_q[comp_q], mr_q);
					end
				end
				OP_OUT: begin
					out_data_q <= {vel_q[2], vel_q[1], vel_q[0], pos_q[2], pos_q[1], pos_q[0]};
					out_skip_q <= skip_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign s_tready  = ctl.in_ready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = OUT_BITS'(out_data_q);
	assign m_tuser   = out_skip_q;

	`PEI_ASSERT_NEXT(a_skip_to_out, s_tvalid && s_tready && (inv_mass_q == '0), ctl.cw.op == OP_OUT)

endmodule
